@@ hdl/sha3_pkg.sv @@
// package: shared types, constants and round functions for the sha3 engine
`timescale 1ns / 1ps
`default_nettype none
package sha3_pkg;

    localparam int NUM_ROUNDS = 24;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    typedef logic [63:0] t_lane;
    typedef t_lane [24:0] t_state;

    // item passed from front to back
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
    } t_item;

    function automatic logic [4:0] rate_of(input logic [1:0] mode);
        case (mode)
            2'd0:    rate_of = 5'd18;
            2'd1:    rate_of = 5'd17;
            2'd2:    rate_of = 5'd13;
            default: rate_of = 5'd9;
        endcase
    endfunction

    function automatic logic [3:0] words_of(input logic [1:0] mode);
        case (mode)
            2'd0:    words_of = 4'd4;
            2'd1:    words_of = 4'd4;
            2'd2:    words_of = 4'd6;
            default: words_of = 4'd8;
        endcase
    endfunction

    function automatic logic [5:0] rot_of(input int i);
        case (i)
            0: rot_of = 6'd0;   1: rot_of = 6'd1;   2: rot_of = 6'd62;  3: rot_of = 6'd28;
            4: rot_of = 6'd27;  5: rot_of = 6'd36;  6: rot_of = 6'd44;  7: rot_of = 6'd6;
            8: rot_of = 6'd55;  9: rot_of = 6'd20;  10: rot_of = 6'd3;  11: rot_of = 6'd10;
            12: rot_of = 6'd43; 13: rot_of = 6'd25; 14: rot_of = 6'd39; 15: rot_of = 6'd41;
            16: rot_of = 6'd45; 17: rot_of = 6'd15; 18: rot_of = 6'd21; 19: rot_of = 6'd8;
            20: rot_of = 6'd18; 21: rot_of = 6'd2;  22: rot_of = 6'd61; 23: rot_of = 6'd56;
            default: rot_of = 6'd14;
        endcase
    endfunction

    function automatic t_lane rotl(input t_lane v, input logic [5:0] n);
        logic [127:0] w;
        w = {v, v} << n;
        rotl = w[127:64];
    endfunction

    // round constant from the lfsr value at round start
    function automatic t_lane round_const(input logic [7:0] lfsr_in);
        t_lane rc;
        logic [7:0] l;
        rc = '0;
        l = lfsr_in;
        for (int j = 0; j < 7; j++) begin
            if (l[0]) rc[(1 << j) - 1] = 1'b1;
            l = l[7] ? ({l[6:0], 1'b0} ^ 8'h71) : {l[6:0], 1'b0};
        end
        round_const = rc;
    endfunction

    function automatic logic [7:0] lfsr_step7(input logic [7:0] lfsr_in);
        logic [7:0] l;
        l = lfsr_in;
        for (int j = 0; j < 7; j++) begin
            l = l[7] ? ({l[6:0], 1'b0} ^ 8'h71) : {l[6:0], 1'b0};
        end
        lfsr_step7 = l;
    endfunction

    function automatic t_state keccak_round(input t_state a_in, input t_lane rc);
        t_lane c [5];
        t_lane d;
        t_state a, b, r;
        a = a_in;
        for (int x = 0; x < 5; x++) begin
            c[x] = a[x] ^ a[x + 5] ^ a[x + 10] ^ a[x + 15] ^ a[x + 20];
        end
        for (int x = 0; x < 5; x++) begin
            d = c[(x + 4) % 5] ^ rotl(c[(x + 1) % 5], 6'd1);
            for (int y = 0; y < 5; y++) a[x + 5 * y] = a[x + 5 * y] ^ d;
        end
        for (int x = 0; x < 5; x++) begin
            for (int y = 0; y < 5; y++) begin
                b[y + 5 * ((2 * x + 3 * y) % 5)] = rotl(a[x + 5 * y], rot_of(x + 5 * y));
            end
        end
        for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 5; x++) begin
                r[x + 5 * y] = b[x + 5 * y] ^ (~b[(x + 1) % 5 + 5 * y] & b[(x + 2) % 5 + 5 * y]);
            end
        end
        r[0] = r[0] ^ rc;
        keccak_round = r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/sha3_front.sv @@
// front end: input capture, byte masking and request queue
`timescale 1ns / 1ps
`default_nettype none
module sha3_front #(
    parameter int DEPTH = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  [63:0]         i_data_word,
    input  wire  [3:0]          i_byte_count,
    input  wire                 i_last_word,
    output logic                o_q_valid,
    output sha3_pkg::t_item     o_q_item,
    input  wire                 i_q_pop
);
    import sha3_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [AW:0]    r_cnt;
    logic           push;
    t_item          item;
    logic [3:0]     cnt;
    logic [63:0]    mask;

    assign o_stall = (r_cnt == AW'(0) + (AW+1)'(DEPTH));
    assign push    = i_valid && !o_stall;

    // clamp count and clear unused bytes
    always_comb begin
        cnt = (i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
        for (int k = 0; k < 8; k++) mask[8*k +: 8] = (4'(k) < cnt) ? 8'hff : 8'h00;
        item.data  = i_data_word & mask;
        item.count = cnt;
        item.last  = i_last_word;
    end

    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_q_pop) r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(i_q_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_q_pop |-> o_q_valid)
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue overfull");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_q_pop) |=> (r_cnt == $past(r_cnt) + 1'b1)) else $error("count slip");
endmodule
`default_nettype wire

@@ hdl/sha3_back.sv @@
// back end: absorb, padding, round sequencer and digest output
`timescale 1ns / 1ps
`default_nettype none
module sha3_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  [1:0]          i_mode,
    input  wire                 i_q_valid,
    input  sha3_pkg::t_item     i_q_item,
    output logic                o_q_pop,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [63:0]         o_digest_word,
    output logic                o_digest_last
);
    import sha3_pkg::*;

    typedef enum logic [2:0] {S_TAKE, S_PRE, S_PERM, S_PAD, S_OUT} t_st;

    t_st        r_st;
    t_state     r_lanes;
    logic [4:0] r_pos;
    logic [4:0] r_round;
    logic [7:0] r_lfsr;
    logic       r_fin;    // permutation is the final one of a message
    logic       r_post;   // after this permutation go to pad step
    logic       r_redo;   // held request still to be absorbed after this permutation
    logic [3:0] r_k;
    t_item      r_it;
    logic [4:0] rate;
    logic [3:0] nwords;
    t_lane      w;
    t_state     pad_lanes;

    assign rate    = rate_of(i_mode);
    assign nwords  = words_of(i_mode);
    assign o_q_pop = (r_st == S_TAKE) && i_q_valid;

    always_comb begin
        w = r_lanes[r_k[2:0]];
        if (i_mode == 2'd0 && r_k == nwords - 1'b1) w[63:32] = '0;
    end

    // domain bits and pad10*1 on the current block
    always_comb begin
        pad_lanes = r_lanes;
        pad_lanes[r_pos] = pad_lanes[r_pos] ^ r_it.data
            ^ (64'h06 << {r_it.count[2:0], 3'b000});
        pad_lanes[rate - 1'b1][63] = ~pad_lanes[rate - 1'b1][63];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_TAKE;
            r_lanes <= '0;
            r_pos   <= '0;
            r_round <= '0;
            r_lfsr  <= 8'h01;
            r_fin   <= 1'b0;
            r_post  <= 1'b0;
            r_redo  <= 1'b0;
            r_k     <= '0;
            o_valid <= 1'b0;
        end else begin
            case (r_st)
                S_TAKE: begin
                    if (i_q_valid) begin
                        r_it <= i_q_item;
                        r_st <= S_PRE;
                    end
                end
                S_PRE: begin
                    if (r_pos >= rate) begin
                        // mode shrank the rate mid-message
                        r_pos  <= '0;
                        r_fin  <= 1'b0;
                        r_post <= 1'b0;
                        r_redo <= 1'b1;
                        r_st   <= S_PERM;
                    end else if (!r_it.last || r_it.count == 4'd8) begin
                        r_lanes[r_pos] <= r_lanes[r_pos] ^ r_it.data;
                        if (r_pos + 1'b1 >= rate) begin
                            r_pos  <= '0;
                            r_fin  <= 1'b0;
                            r_post <= r_it.last;
                            r_redo <= 1'b0;
                            r_st   <= S_PERM;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                            r_st  <= r_it.last ? S_PAD : S_TAKE;
                        end
                        r_it.count <= 4'd0;
                        r_it.data  <= '0;
                    end else begin
                        r_st <= S_PAD;
                    end
                end
                S_PAD: begin
                    r_lanes <= pad_lanes;
                    r_fin   <= 1'b1;
                    r_post  <= 1'b0;
                    r_redo  <= 1'b0;
                    r_st    <= S_PERM;
                end
                S_PERM: begin
                    r_lanes <= keccak_round(r_lanes, round_const(r_lfsr));
                    if (r_round == 5'(NUM_ROUNDS - 1)) begin
                        r_round <= '0;
                        r_lfsr  <= 8'h01;
                        if (r_fin) begin
                            r_k  <= '0;
                            r_st <= S_OUT;
                        end else if (r_post) begin
                            r_st <= S_PAD;
                        end else begin
                            r_st <= r_redo ? S_PRE : S_TAKE;
                        end
                    end else begin
                        r_round <= r_round + 1'b1;
                        r_lfsr  <= lfsr_step7(r_lfsr);
                    end
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        if (o_valid && o_digest_last) begin
                            o_valid <= 1'b0;
                            r_lanes <= '0;
                            r_pos   <= '0;
                            r_st    <= S_TAKE;
                        end else begin
                            o_valid       <= 1'b1;
                            o_digest_word <= w;
                            o_digest_last <= (r_k == nwords - 1'b1);
                            r_k           <= r_k + 1'b1;
                        end
                    end
                end
                default: r_st <= S_TAKE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_PERM) |-> (r_round == 5'd0)) else $error("round count off");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_st == S_PRE)) else $error("pop without absorb");
endmodule
`default_nettype wire

@@ hdl/sha3_hash_engine.sv @@
// top level of the sha3 hash engine
`timescale 1ns / 1ps
`default_nettype none
// sha3 hash engine, keccak-f[1600] with one round per clock
// input channel: i_valid / o_stall carry message words (data, byte count,
//   last flag); a short request queue takes words while a permutation runs
// output channel: o_valid / i_stall carry digest words, o_digest_last on
//   the final one (4, 4, 6 or 8 words for 224/256/384/512)
// config channel: i_cfg_valid / o_cfg_ready writes the 2-bit digest mode;
//   write only while idle
// absorb: each word passes the take and absorb states, and each full rate
//   block then runs 24 rounds on the shared round unit
// after the last word: pad step, 24 rounds, then one digest word a cycle
//   unless stalled; a full last word filling the block adds 24 rounds first
// reset: state cleared, mode 256, queue emptied
// output stall: the digest word holds; the queue keeps accepting until full
module sha3_hash_engine #(
    parameter int QUEUE_DEPTH = sha3_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [63:0] i_data_word,
    input  wire  [3:0]  i_byte_count,
    input  wire         i_last_word,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [63:0] o_digest_word,
    output logic        o_digest_last,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_data
);
    import sha3_pkg::*;

    logic [1:0] r_mode;
    logic       q_valid, q_pop;
    t_item      q_item;

    assign o_cfg_ready = 1'b1;

    // digest mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'd1;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    sha3_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_data_word, .i_byte_count, .i_last_word,
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    sha3_back u_back (
        .i_clk, .i_rst_n, .i_mode(r_mode),
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop),
        .o_valid, .i_stall, .o_digest_word, .o_digest_last
    );
endmodule
`default_nettype wire
